// ===== rtl/core/blu_pkg.sv =====
package blu_pkg;

  localparam int DATA_W    = 32;
  localparam int BAND_W    = 5;
  localparam int ROW_W     = 6;
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = 6;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_FACTOR = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_BAD    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PIVOT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic [1:0] CFG_ORDER = 2'd0;
  localparam logic [1:0] CFG_LOWER = 2'd1;
  localparam logic [1:0] CFG_UPPER = 2'd2;

  typedef enum logic [1:0] {
    K_WRITE,
    K_FACTOR,
    K_READ,
    K_BAD
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [3:0]         row;
    logic [5:0]         col;
    logic [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [1:0]        status;
  } res_t;

  // {saturated, value} from a sign and a magnitude
  function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [DIV_W-1:0] m);
    logic [DATA_W:0] r;
    if (!neg) begin
      if (m > DIV_W'(32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, m[DATA_W-1:0]};
    end else begin
      if (m > DIV_W'(32'h8000_0000)) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, -m[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/blu_queue.sv =====
module blu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== rtl/core/blu_front.sv =====
module blu_front
  import blu_pkg::*;
#(
  parameter int IW = 7
) (
  input  logic [1:0]        operation_i,
  input  logic [3:0]        band_row_i,
  input  logic [5:0]        column_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [IW-1:0]     order_i,
  input  logic [BAND_W-1:0] kl_i,
  input  logic [BAND_W-1:0] ku_i,
  output cmd_t              cmd_o
);

  logic in_range;

  assign in_range = (32'(band_row_i) <= 32'(kl_i) + 32'(ku_i)) &&
                    (32'(column_i) < 32'(order_i));

  always_comb begin
    cmd_o.row   = band_row_i;
    cmd_o.col   = column_i;
    cmd_o.value = value_i;
    unique case (operation_i)
      OP_FACTOR: cmd_o.kind = K_FACTOR;
      OP_WRITE:  cmd_o.kind = in_range ? K_WRITE : K_BAD;
      OP_READ:   cmd_o.kind = in_range ? K_READ : K_BAD;
      default:   cmd_o.kind = K_BAD;
    endcase
  end

endmodule

// ===== rtl/core/blu_divider.sv =====
module blu_divider
  import blu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  num_i,
  input  logic [DATA_W-1:0] den_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quo_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]    rem_q, den_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DATA_W:0]      trial, diff;

  assign done_o = (cnt_q == '0);
  assign quo_o  = quo_q;
  assign trial  = {rem_q, quo_q[DIV_W-1]};
  assign diff   = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/blu_back.sv =====
module blu_back
  import blu_pkg::*;
#(
  parameter int IW     = 7,
  parameter int STRIDE = 9,
  parameter int DEPTH  = 576
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output res_t              res_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  input  logic [IW-1:0]     order_i,
  input  logic [BAND_W-1:0] kl_i,
  input  logic [BAND_W-1:0] ku_i
);

  localparam int AW = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD_WAIT = 4'd1;
  localparam logic [3:0] S_RESULT  = 4'd2;
  localparam logic [3:0] S_COL     = 4'd3;
  localparam logic [3:0] S_PIV_WT  = 4'd4;
  localparam logic [3:0] S_L_WT    = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_U_RD    = 4'd7;
  localparam logic [3:0] S_T_RD    = 4'd8;
  localparam logic [3:0] S_MUL     = 4'd9;
  localparam logic [3:0] S_RND     = 4'd10;
  localparam logic [3:0] S_SUB     = 4'd11;
  localparam logic [3:0] S_NEXT_A  = 4'd12;

  function automatic logic [AW-1:0] addr_of(input logic [ROW_W-1:0] r, input logic [IW-1:0] c);
    return AW'(r) + AW'(c) * AW'(STRIDE);
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  logic [3:0]          state_q;
  logic [IW-1:0]       i_q;
  logic [BAND_W-1:0]   a_q, b_q, mi_q, mj_q;
  logic                sat_q, div_neg_q;
  logic [DATA_W-1:0]   piv_q, l_q, u_q, t_q, m_q;
  logic signed [63:0]  prod_q;
  res_t                res_q;

  logic [IW-1:0]       rest;
  logic [BAND_W-1:0]   mi, mj, a_sel;
  logic                last_col;
  logic [AW-1:0]       cmd_addr, piv_addr, l_addr, u_addr, t_addr;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic [DATA_W-1:0]   abs_a, abs_p;
  logic [DIV_W-1:0]    div_num, quo;
  logic                div_start, div_done;
  logic [DATA_W:0]     div_sat, mul_sat;
  logic [63:0]         prod_mag, prod_rnd;
  logic [DATA_W:0]     diff;
  logic                diff_ovf;
  logic [DATA_W-1:0]   diff_sat;
  logic                idle_take;

  assign rest     = order_i - i_q - 1'b1;
  assign mi       = (32'(kl_i) < 32'(rest)) ? kl_i : BAND_W'(rest);
  assign mj       = (32'(ku_i) < 32'(rest)) ? ku_i : BAND_W'(rest);
  assign last_col = (32'(i_q) + 32'd1 >= 32'(order_i));
  assign a_sel    = (state_q == S_NEXT_A) ? a_q + 1'b1 : a_q;

  assign cmd_addr = addr_of(ROW_W'(cmd_i.row), IW'(cmd_i.col));
  assign piv_addr = addr_of(ROW_W'(ku_i), i_q);
  assign l_addr   = addr_of(ROW_W'(ku_i) + ROW_W'(a_sel) + 1'b1, i_q);
  assign u_addr   = addr_of(ROW_W'(ku_i) - ROW_W'(b_q) - 1'b1, i_q + IW'(b_q) + 1'b1);
  assign t_addr   = addr_of(ROW_W'(ku_i) + ROW_W'(a_q) - ROW_W'(b_q),
                            i_q + IW'(b_q) + 1'b1);

  assign abs_a     = rdata_q[DATA_W-1] ? -rdata_q : rdata_q;
  assign abs_p     = piv_q[DATA_W-1] ? -piv_q : piv_q;
  assign div_num   = {abs_a, 16'b0} + DIV_W'(abs_p >> 1);
  assign div_start = (state_q == S_L_WT);
  assign div_sat   = sat_mag(div_neg_q, quo);

  assign prod_mag = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
  assign prod_rnd = prod_mag + 64'd32768;
  assign mul_sat  = sat_mag(prod_q[63], prod_rnd[63:16]);

  assign diff     = {t_q[DATA_W-1], t_q} - {m_q[DATA_W-1], m_q};
  assign diff_ovf = diff[DATA_W] != diff[DATA_W-1];
  assign diff_sat = !diff_ovf ? diff[DATA_W-1:0] :
                    (diff[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  blu_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (abs_p),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign idle_take = (state_q == S_IDLE) && !cmd_empty_i;

  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = res_q;
    if (idle_take) begin
      res_o.read_value = '0;
      res_o.status     = (cmd_i.kind == K_WRITE) ? ST_OK : ST_RANGE;
      if (cmd_i.kind == K_READ || cmd_i.kind == K_FACTOR) begin
        cmd_pop_o = 1'b1;
      end else if (!res_full_i) begin
        cmd_pop_o  = 1'b1;
        res_push_o = 1'b1;
      end
    end else if (state_q == S_RESULT) begin
      res_push_o = !res_full_i;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cmd_addr;
    wr_en   = 1'b0;
    wr_addr = cmd_addr;
    wr_data = cmd_i.value;
    unique case (state_q)
      S_IDLE: begin
        rd_en = idle_take && cmd_i.kind == K_READ;
        wr_en = idle_take && cmd_i.kind == K_WRITE && !res_full_i;
      end
      S_COL: begin
        rd_en   = 1'b1;
        rd_addr = piv_addr;
      end
      S_PIV_WT, S_NEXT_A: begin
        rd_en   = 1'b1;
        rd_addr = l_addr;
      end
      S_U_RD: begin
        rd_en   = 1'b1;
        rd_addr = u_addr;
      end
      S_T_RD: begin
        rd_en   = 1'b1;
        rd_addr = t_addr;
      end
      S_DIV: begin
        wr_en   = div_done;
        wr_addr = l_addr;
        wr_data = div_sat[DATA_W-1:0];
      end
      S_SUB: begin
        wr_en   = 1'b1;
        wr_addr = t_addr;
        wr_data = diff_sat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_RD_WAIT: res_q <= '{read_value: rdata_q, status: ST_OK};
      S_COL:     if (last_col) res_q <= '{read_value: '0, status: sat_q ? ST_SAT : ST_OK};
      S_PIV_WT: begin
        piv_q <= rdata_q;
        res_q <= '{read_value: '0, status: ST_PIVOT};
      end
      S_L_WT:    div_neg_q <= rdata_q[DATA_W-1] ^ piv_q[DATA_W-1];
      S_DIV:     if (div_done) l_q <= div_sat[DATA_W-1:0];
      S_T_RD:    u_q <= rdata_q;
      S_MUL: begin
        t_q    <= rdata_q;
        prod_q <= $signed(l_q) * $signed(u_q);
      end
      S_RND:     m_q <= mul_sat[DATA_W-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      a_q     <= '0;
      b_q     <= '0;
      mi_q    <= '0;
      mj_q    <= '0;
      sat_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (idle_take && cmd_i.kind == K_READ) begin
            state_q <= S_RD_WAIT;
          end else if (idle_take && cmd_i.kind == K_FACTOR) begin
            state_q <= S_COL;
            i_q     <= '0;
            sat_q   <= 1'b0;
          end
        end
        S_RD_WAIT: state_q <= S_RESULT;
        S_RESULT:  if (!res_full_i) state_q <= S_IDLE;
        S_COL: begin
          a_q  <= '0;
          mi_q <= mi;
          mj_q <= mj;
          if (last_col) state_q <= S_RESULT;
          else if (mi == '0) i_q <= i_q + 1'b1;
          else state_q <= S_PIV_WT;
        end
        S_PIV_WT: state_q <= (rdata_q == '0) ? S_RESULT : S_L_WT;
        S_L_WT:   state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            sat_q   <= sat_q | div_sat[DATA_W];
            b_q     <= '0;
            state_q <= (mj_q == '0) ? S_NEXT_A : S_U_RD;
          end
        end
        S_U_RD: state_q <= S_T_RD;
        S_T_RD: state_q <= S_MUL;
        S_MUL:  state_q <= S_RND;
        S_RND: begin
          sat_q   <= sat_q | mul_sat[DATA_W];
          state_q <= S_SUB;
        end
        S_SUB: begin
          sat_q <= sat_q | diff_ovf;
          b_q   <= b_q + 1'b1;
          state_q <= (b_q + 1'b1 == mj_q) ? S_NEXT_A : S_U_RD;
        end
        S_NEXT_A: begin
          if (a_q + 1'b1 == mi_q) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_COL;
          end else begin
            a_q     <= a_q + 1'b1;
            state_q <= S_L_WT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result transfer into full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !cmd_empty_i) else $error("command taken from empty queue");

  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_IDLE || state_q == S_DIV || state_q == S_SUB))
    else $error("store written outside a write step");

  a_mul_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_RND)) else $error("product step skipped");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_L_WT) |=> (state_q == S_DIV && !div_done))
    else $error("divider did not start");

endmodule

// ===== rtl/core/band_lu_factorizer.sv =====
// Write and out-of-range items are answered directly from idle; a read goes through the registered store read.
// Factor: per pivot column with m sub-entries and w super-entries, each sub-entry is
// divided by the pivot in the 48-step divider, then updates its w entries in turn.
// Up to two items queue ahead of the execution unit and two results queue behind it.
// Reset clears control, queues and registers (order 64, bandwidths 1); the store
// holds no defined value until written.
module band_lu_factorizer
  import blu_pkg::*;
#(
  parameter int MAX_ORDER       = 64,
  parameter int MAX_LOWER_BANDS = 4,
  parameter int MAX_UPPER_BANDS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        operation_i,
  input  logic [3:0]        band_row_i,
  input  logic [5:0]        column_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] read_value_o,
  output logic [1:0]        status_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [6:0]        cfg_data_i
);

  localparam int STRIDE = MAX_LOWER_BANDS + MAX_UPPER_BANDS + 1;
  localparam int DEPTH  = MAX_ORDER * STRIDE;
  localparam int IW     = $clog2(MAX_ORDER + 1);

  logic [6:0]        order_q;
  logic [2:0]        lower_q, upper_q;
  logic [IW-1:0]     order;
  logic [BAND_W-1:0] kl, ku;
  cmd_t              cmd_in, cmd_out;
  logic              cmd_empty, cmd_pop;
  res_t              res_in, res_out;
  logic              res_full, res_push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 7'd64;
      lower_q <= 3'd1;
      upper_q <= 3'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ORDER: order_q <= cfg_data_i;
        CFG_LOWER: lower_q <= cfg_data_i[2:0];
        CFG_UPPER: upper_q <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  assign order = (32'(order_q) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(order_q);
  assign kl = (32'(lower_q) > MAX_LOWER_BANDS) ? BAND_W'(MAX_LOWER_BANDS) : BAND_W'(lower_q);
  assign ku = (32'(upper_q) > MAX_UPPER_BANDS) ? BAND_W'(MAX_UPPER_BANDS) : BAND_W'(upper_q);

  blu_front #(.IW(IW)) u_front (
    .operation_i (operation_i),
    .band_row_i  (band_row_i),
    .column_i    (column_i),
    .value_i     (value_i),
    .order_i     (order),
    .kl_i        (kl),
    .ku_i        (ku),
    .cmd_o       (cmd_in)
  );

  blu_queue #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  blu_back #(.IW(IW), .STRIDE(STRIDE), .DEPTH(DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .order_i     (order),
    .kl_i        (kl),
    .ku_i        (ku)
  );

  blu_queue #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign read_value_o = res_out.read_value;
  assign status_o     = res_out.status;

endmodule

// ===== test/band_lu_factorizer_checker.sv =====
`timescale 1ns / 100ps

module band_lu_factorizer_checker
  import blu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic              full,
  input  logic [1:0]        operation_i,
  input  logic [3:0]        band_row_i,
  input  logic [5:0]        column_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic              empty,
  input  logic              pop,
  input  logic [DATA_W-1:0] read_value_o,
  input  logic [1:0]        status_o,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [6:0]        cfg_data_i,
  output int                error_count,
  output int                outstanding,
  output int                checked_count,
  output int                pivot_stops,
  output int                sat_factors
);

  localparam int ORDER_CAP = 64;
  localparam int LOW_CAP   = 4;
  localparam int UP_CAP    = 4;
  localparam int PITCH     = LOW_CAP + UP_CAP + 1;

  logic signed [DATA_W-1:0] band_mem [ORDER_CAP*PITCH];
  bit                       sat_flag;
  logic [6:0]               order_reg;
  logic [2:0]               low_reg;
  logic [2:0]               up_reg;
  res_t                     expected_q [$];

  function automatic int eff_order();
    return (order_reg > ORDER_CAP) ? ORDER_CAP : int'(order_reg);
  endfunction

  function automatic int eff_low();
    return (low_reg > LOW_CAP) ? LOW_CAP : int'(low_reg);
  endfunction

  function automatic int eff_up();
    return (up_reg > UP_CAP) ? UP_CAP : int'(up_reg);
  endfunction

  function automatic logic signed [DATA_W-1:0] clip(longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] q_mul(logic signed [DATA_W-1:0] a,
                                                     logic signed [DATA_W-1:0] b);
    longint          p;
    longint unsigned m;
    longint          r;
    p = longint'(a) * longint'(b);
    m = (p < 0) ? longint'(-p) : p;
    r = longint'((m + 64'd32768) >> 16);
    return clip((p < 0) ? -r : r);
  endfunction

  function automatic logic signed [DATA_W-1:0] q_div(logic signed [DATA_W-1:0] a,
                                                     logic signed [DATA_W-1:0] d);
    longint unsigned num;
    longint unsigned den;
    longint          q;
    num = ((a < 0) ? -longint'(a) : longint'(a)) << 16;
    den = (d < 0) ? -longint'(d) : longint'(d);
    q   = longint'((num + den / 2) / den);
    return clip(((a < 0) != (d < 0)) ? -q : q);
  endfunction

  function automatic logic [1:0] factor_band();
    int                       n;
    int                       kl;
    int                       ku;
    int                       rest;
    int                       mi;
    int                       mj;
    int                       t;
    logic signed [DATA_W-1:0] piv;
    logic signed [DATA_W-1:0] l;
    logic signed [DATA_W-1:0] u;
    n        = eff_order();
    kl       = eff_low();
    ku       = eff_up();
    sat_flag = 1'b0;
    for (int i = 0; i + 1 < n; i++) begin
      rest = n - i - 1;
      mi   = (kl < rest) ? kl : rest;
      mj   = (ku < rest) ? ku : rest;
      if (mi == 0) continue;
      piv = band_mem[ku + i * PITCH];
      if (piv == 0) return ST_PIVOT;
      for (int a = 0; a < mi; a++) begin
        t = ku + 1 + a + i * PITCH;
        band_mem[t] = q_div(band_mem[t], piv);
      end
      for (int a = 0; a < mi; a++) begin
        l = band_mem[ku + 1 + a + i * PITCH];
        for (int b = 0; b < mj; b++) begin
          u = band_mem[(ku - 1 - b) + (i + 1 + b) * PITCH];
          t = (ku + a - b) + (i + 1 + b) * PITCH;
          band_mem[t] = clip(longint'(band_mem[t]) - longint'(q_mul(l, u)));
        end
      end
    end
    return sat_flag ? ST_SAT : ST_OK;
  endfunction

  function automatic res_t predict_result(logic [1:0] op, logic [3:0] row, logic [5:0] col,
                                          logic [DATA_W-1:0] val);
    res_t r;
    r = '0;
    if (op == OP_FACTOR) begin
      r.status = factor_band();
    end else if (op == OP_WRITE || op == OP_READ) begin
      if (int'(row) > eff_low() + eff_up() || int'(col) >= eff_order()) begin
        r.status = ST_RANGE;
      end else if (op == OP_WRITE) begin
        band_mem[int'(row) + int'(col) * PITCH] = val;
      end else begin
        r.read_value = band_mem[int'(row) + int'(col) * PITCH];
      end
    end else begin
      r.status = ST_RANGE;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] exp_v,
                                 logic [DATA_W-1:0] got_v);
    $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    error_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      expected_q.delete();
      order_reg     = 7'd64;
      low_reg       = 3'd1;
      up_reg        = 3'd1;
      sat_flag      = 1'b0;
      error_count   = 0;
      checked_count = 0;
      pivot_stops   = 0;
      sat_factors   = 0;
      outstanding   = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", '0, read_value_o);
        end else begin
          want = expected_q.pop_front();
          if (read_value_o !== want.read_value)
            report_mismatch("read_value", want.read_value, read_value_o);
          if (status_o !== want.status)
            report_mismatch("status", DATA_W'(want.status), DATA_W'(status_o));
          checked_count++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ORDER: order_reg = cfg_data_i;
          CFG_LOWER: low_reg   = cfg_data_i[2:0];
          CFG_UPPER: up_reg    = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        want = predict_result(operation_i, band_row_i, column_i, value_i);
        if (operation_i == OP_FACTOR && want.status == ST_PIVOT) pivot_stops++;
        if (operation_i == OP_FACTOR && want.status == ST_SAT) sat_factors++;
        expected_q.push_back(want);
      end
      outstanding = expected_q.size();
    end
  end

endmodule

// ===== test/band_lu_factorizer_test.sv =====
`timescale 1ns / 100ps

module band_lu_factorizer_test;
  import blu_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        operation_i = OP_WRITE;
  logic [3:0]        band_row_i = '0;
  logic [5:0]        column_i = '0;
  logic [DATA_W-1:0] value_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [DATA_W-1:0] read_value_o;
  logic [1:0]        status_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = CFG_ORDER;
  logic [6:0]        cfg_data_i = '0;

  int error_count;
  int outstanding;
  int checked_count;
  int pivot_stops;
  int sat_factors;
  int burst_left = 0;
  int sent_items = 0;
  int factor_items = 0;
  int phase_count = 0;
  bit hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  band_lu_factorizer dut (.*);

  band_lu_factorizer_checker checker_i (.*);

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stall patterns, long hold-off on request
  initial begin
    int mode;
    int span;
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 60);
        repeat (span) begin
          case (mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= 1'($urandom_range(0, 1));
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] row, logic [5:0] col,
                           logic [DATA_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    push        <= 1'b1;
    operation_i <= op;
    band_row_i  <= row;
    column_i    <= col;
    value_i     <= val;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_items++;
    if (op == OP_FACTOR) factor_items++;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_shape(logic [6:0] order, logic [2:0] lo, logic [2:0] up);
    drain();
    write_reg(CFG_ORDER, order);
    write_reg(CFG_LOWER, {4'($urandom), lo});
    write_reg(CFG_UPPER, {4'($urandom), up});
    phase_count++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    logic [DATA_W-1:0] mag;
    sel = $urandom_range(0, 99);
    if (sel < 3) return '0;
    if (sel < 20) return $urandom;
    mag = $urandom_range(32'h0000_4000, 32'h0004_0000);
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  task automatic random_phase(int count, int order_hint, int factor_pct);
    int sel;
    logic [1:0] op;
    logic [3:0] row;
    logic [5:0] col;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < factor_pct) op = OP_FACTOR;
      else if (sel < factor_pct + 3) op = OP_BAD;
      else if (sel < 55) op = OP_WRITE;
      else op = OP_READ;
      row = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
      col = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, order_hint));
      send_item(op, row, col, pick_value());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every slot so no later access touches an unwritten entry
    set_shape(7'd64, 3'd4, 3'd4);
    for (int c = 0; c < 64; c++)
      for (int r = 0; r < 9; r++)
        send_item(OP_WRITE, 4'(r), 6'(c), (r == 4) ? 32'h0004_0000 : pick_value() | 32'h1);

    send_item(OP_WRITE, 4'd0, 6'd0, 32'h7FFF_FFFF);
    send_item(OP_READ, 4'd0, 6'd0, '0);
    send_item(OP_WRITE, 4'd8, 6'd63, 32'h8000_0000);
    send_item(OP_READ, 4'd8, 6'd63, '1);
    send_item(OP_WRITE, 4'd9, 6'd1, 32'h1234_5678);
    send_item(OP_READ, 4'd15, 6'd2, '0);
    send_item(OP_BAD, 4'd1, 6'd1, '1);
    send_item(OP_WRITE, 4'd4, 6'd0, '0);
    send_item(OP_FACTOR, 4'd0, 6'd0, '0);
    send_item(OP_READ, 4'd5, 6'd0, '0);
    send_item(OP_WRITE, 4'd4, 6'd0, 32'h0001_0000);
    send_item(OP_WRITE, 4'd5, 6'd0, 32'h7FFF_0000);
    send_item(OP_WRITE, 4'd3, 6'd1, 32'h7FFF_0000);
    set_shape(7'd0, 3'd0, 3'd0);
    send_item(OP_WRITE, 4'd0, 6'd0, 32'h0001_0000);
    send_item(OP_READ, 4'd0, 6'd0, '0);
    send_item(OP_FACTOR, 4'd0, 6'd0, '0);
    set_shape(7'd127, 3'd7, 3'd7);
    send_item(OP_READ, 4'd8, 6'd63, '0);
    send_item(OP_READ, 4'd9, 6'd0, '0);
    set_shape(7'd3, 3'd4, 3'd4);
    send_item(OP_FACTOR, 4'd0, 6'd0, '0);
    send_item(OP_READ, 4'd5, 6'd0, '0);
    set_shape(7'd1, 3'd1, 3'd1);
    send_item(OP_FACTOR, 4'd0, 6'd0, '0);
    send_item(OP_READ, 4'd1, 6'd0, '0);

    // fill the result queue while the receiver holds off
    set_shape(7'd8, 3'd2, 3'd2);
    hold_req = 1'b1;
    random_phase(40, 7, 0);

    for (int p = 0; p < 11; p++) begin
      if (p % 4 == 3)
        set_shape(($urandom_range(0, 1) != 0) ? 7'd64 : 7'($urandom_range(65, 127)),
                  3'($urandom), 3'($urandom));
      else
        set_shape(7'($urandom_range(1, 12)), 3'($urandom), 3'($urandom));
      random_phase(105, 63, (p % 4 == 3) ? 2 : 5);
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("%0d items in %0d shapes, %0d factorizations (%0d zero-pivot, %0d saturated)",
             sent_items, phase_count, factor_items, pivot_stops, sat_factors);
    $display("%0d results checked, %0d mismatches", checked_count, error_count);
    if (error_count == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
